@@ design/sixteen_bit_register_cpu_core_defines.svh @@
// Assertion macros used by the port checker file.
`ifndef SIXTEEN_BIT_REGISTER_CPU_CORE_DEFINES_SVH
`define SIXTEEN_BIT_REGISTER_CPU_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define SBR_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define SBR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/sbrcpu_pkg.sv @@
// Package with the beat types, opcodes and controller types of the CPU core.
package sbrcpu_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [15:0] data_word;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic [15:0] program_counter;
        logic [15:0] executed_word;
        logic        halted;
        logic        divide_fault;
        logic [1:0]  flag_bits;
    } out_beat_t;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_MEMRD = 2'd2;
    localparam logic [1:0] CMD_REGRD = 2'd3;

    localparam logic [3:0] OP_LW = 4'd0;
    localparam logic [3:0] OP_SW = 4'd1;
    localparam logic [3:0] OP_NAND = 4'd2;
    localparam logic [3:0] OP_NANDI = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADDI = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_MUL = 4'd7;
    localparam logic [3:0] OP_DIV = 4'd8;
    localparam logic [3:0] OP_CMP = 4'd9;
    localparam logic [3:0] OP_B = 4'd10;
    localparam logic [3:0] OP_BEQ = 4'd11;
    localparam logic [3:0] OP_BGT = 4'd12;

    localparam logic [3:0] REG_PC = 4'd10;
    localparam logic [3:0] REG_FLAG = 4'd12;
    localparam logic [3:0] REG_HI = 4'd13;
    localparam logic [3:0] REG_LO = 4'd14;
    localparam logic [3:0] REG_ZERO = 4'd15;
    localparam logic [15:0] HALT_WORD = 16'hFFFF;

    // Memory address source.
    typedef enum logic [1:0] {
        ASEL_CMD = 2'd0,
        ASEL_PC = 2'd1,
        ASEL_EA = 2'd2,
        ASEL_CLR = 2'd3
    } asel_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic        mem_rd;
        logic        mem_wr_cmd;
        logic        mem_wr_sw;
        logic        mem_wr_clr;
        asel_t       asel;
        logic        clr_step;
        logic        latch_item;
        logic        latch_word;
        logic        latch_imm;
        logic        pc_dec;
        logic        latch_ops;
        logic        mul_go;
        logic        div_go;
        logic        div_step;
        logic        write_back;
        logic        lw_back;
        logic        emit;
    } ctl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       clr_last;
        logic [1:0] command;
        logic [3:0] opcode;
        logic       halted;
        logic       div_last;
    } dp_stat_t;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE = 11'b00000000010,
        ST_MEMRD = 11'b00000000100,
        ST_FETCH = 11'b00000001000,
        ST_DECODE = 11'b00000010000,
        ST_IMM = 11'b00000100000,
        ST_OPS = 11'b00001000000,
        ST_EXEC = 11'b00010000000,
        ST_DIV = 11'b00100000000,
        ST_LWRD = 11'b01000000000,
        ST_DONE = 11'b10000000000
    } state_t;

endpackage

@@ design/sbrcpu_ram.sv @@
// Generic single-port RAM with registered read.
module sbrcpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

@@ design/sbrcpu_ctrl.sv @@
// Controller state machine of the CPU core.
module sbrcpu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sbrcpu_pkg::dp_stat_t stat,
    output sbrcpu_pkg::ctl_cmd_t cmd,
    output logic                 busy
);
    sbrcpu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbrcpu_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != sbrcpu_pkg::ST_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.asel = sbrcpu_pkg::ASEL_CMD;
        state_next = state_reg;
        unique case (state_reg)
            sbrcpu_pkg::ST_CLEAR:
            begin
                cmd.asel = sbrcpu_pkg::ASEL_CLR;
                cmd.mem_wr_clr = 1'b1;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = sbrcpu_pkg::ST_IDLE;
                end
            end
            sbrcpu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_item = 1'b1;
                    state_next = sbrcpu_pkg::ST_MEMRD;
                end
            end
            sbrcpu_pkg::ST_MEMRD:
            begin
                // Dispatch on the latched command.
                unique case (stat.command)
                    sbrcpu_pkg::CMD_LOAD:
                    begin
                        cmd.mem_wr_cmd = 1'b1;
                        state_next = sbrcpu_pkg::ST_DONE;
                    end
                    sbrcpu_pkg::CMD_MEMRD:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = sbrcpu_pkg::ST_DONE;
                    end
                    sbrcpu_pkg::CMD_REGRD:
                    begin
                        state_next = sbrcpu_pkg::ST_DONE;
                    end
                    default:
                    begin
                        if (stat.halted)
                        begin
                            state_next = sbrcpu_pkg::ST_DONE;
                        end
                        else
                        begin
                            cmd.asel = sbrcpu_pkg::ASEL_PC;
                            cmd.mem_rd = 1'b1;
                            state_next = sbrcpu_pkg::ST_FETCH;
                        end
                    end
                endcase
            end
            sbrcpu_pkg::ST_FETCH:
            begin
                cmd.latch_word = 1'b1;
                state_next = sbrcpu_pkg::ST_DECODE;
            end
            sbrcpu_pkg::ST_DECODE:
            begin
                priority if (stat.opcode == sbrcpu_pkg::OP_LW
                             || stat.opcode == sbrcpu_pkg::OP_SW
                             || stat.opcode == sbrcpu_pkg::OP_NANDI
                             || stat.opcode == sbrcpu_pkg::OP_ADDI)
                begin
                    // Step to the immediate word and read it.
                    cmd.pc_dec = 1'b1;
                    state_next = sbrcpu_pkg::ST_IMM;
                end
                else
                begin
                    state_next = sbrcpu_pkg::ST_OPS;
                end
            end
            sbrcpu_pkg::ST_IMM:
            begin
                cmd.asel = sbrcpu_pkg::ASEL_PC;
                cmd.mem_rd = 1'b1;
                state_next = sbrcpu_pkg::ST_OPS;
            end
            sbrcpu_pkg::ST_OPS:
            begin
                cmd.latch_ops = 1'b1;
                cmd.latch_imm = 1'b1;
                state_next = sbrcpu_pkg::ST_EXEC;
            end
            sbrcpu_pkg::ST_EXEC:
            begin
                priority if (stat.opcode == sbrcpu_pkg::OP_LW)
                begin
                    cmd.asel = sbrcpu_pkg::ASEL_EA;
                    cmd.mem_rd = 1'b1;
                    state_next = sbrcpu_pkg::ST_LWRD;
                end
                else if (stat.opcode == sbrcpu_pkg::OP_SW)
                begin
                    cmd.asel = sbrcpu_pkg::ASEL_EA;
                    cmd.mem_wr_sw = 1'b1;
                    cmd.write_back = 1'b1;
                    state_next = sbrcpu_pkg::ST_DONE;
                end
                else if (stat.opcode == sbrcpu_pkg::OP_MUL)
                begin
                    cmd.mul_go = 1'b1;
                    cmd.write_back = 1'b1;
                    state_next = sbrcpu_pkg::ST_DONE;
                end
                else if (stat.opcode == sbrcpu_pkg::OP_DIV)
                begin
                    cmd.div_go = 1'b1;
                    state_next = sbrcpu_pkg::ST_DIV;
                end
                else
                begin
                    cmd.write_back = 1'b1;
                    state_next = sbrcpu_pkg::ST_DONE;
                end
            end
            sbrcpu_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.write_back = 1'b1;
                    state_next = sbrcpu_pkg::ST_DONE;
                end
            end
            sbrcpu_pkg::ST_LWRD:
            begin
                cmd.lw_back = 1'b1;
                cmd.write_back = 1'b1;
                state_next = sbrcpu_pkg::ST_DONE;
            end
            sbrcpu_pkg::ST_DONE:
            begin
                cmd.emit = 1'b1;
                state_next = sbrcpu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sbrcpu_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

@@ design/sbrcpu_dp.sv @@
// Datapath of the CPU core: register file, memory, multiplier and divider.
module sbrcpu_dp #(
    parameter int MEM_WORDS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbrcpu_pkg::in_beat_t  item,
    input  sbrcpu_pkg::ctl_cmd_t  cmd,
    output sbrcpu_pkg::dp_stat_t  stat,
    output logic                  done,
    output sbrcpu_pkg::out_beat_t result
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    sbrcpu_pkg::in_beat_t item_reg;
    logic [15:0] regs_reg [15];
    logic        halt_reg;
    logic [AW-1:0] clr_reg;
    logic [15:0] word_reg, imm_reg, a_reg, b_reg, t_reg;
    logic        fault_reg;
    logic        done_reg;
    sbrcpu_pkg::out_beat_t out_reg;

    // Divider state: magnitude restoring divide, one bit a step.
    logic [15:0] dq_reg, dr_reg, dd_reg;
    logic [4:0]  dcnt_reg;
    logic        qneg_reg, rneg_reg, dz_reg;

    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_wdata, mem_rdata, ea;
    logic          mem_we;

    logic [3:0] opc, rd, rs, rt;
    assign opc = word_reg[15:12];
    assign rd = word_reg[11:8];
    assign rs = word_reg[7:4];
    assign rt = word_reg[3:0];

    function automatic logic [15:0] rget(input logic [15:0] r [15], input logic [3:0] i);
        logic [15:0] v;
        v = (i == sbrcpu_pkg::REG_ZERO) ? 16'h0 : r[i];
        return v;
    endfunction

    assign ea = a_reg + imm_reg;

    always_comb
    begin
        unique case (cmd.asel)
            sbrcpu_pkg::ASEL_CMD: mem_addr = item_reg.address[AW-1:0];
            sbrcpu_pkg::ASEL_PC:  mem_addr = regs_reg[sbrcpu_pkg::REG_PC][AW-1:0];
            sbrcpu_pkg::ASEL_EA:  mem_addr = ea[AW-1:0];
            default:              mem_addr = clr_reg;
        endcase
        priority if (cmd.mem_wr_clr)
        begin
            mem_wdata = 16'h0;
        end
        else if (cmd.mem_wr_sw)
        begin
            mem_wdata = t_reg;
        end
        else
        begin
            mem_wdata = item_reg.data_word;
        end
    end
    assign mem_we = cmd.mem_wr_clr | cmd.mem_wr_cmd | cmd.mem_wr_sw;

    sbrcpu_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (cmd.mem_rd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Multiplier product, registered straight into hi and lo.
    logic signed [31:0] prod;
    assign prod = $signed(a_reg) * $signed(b_reg);

    // Divider step.
    logic [16:0] dtrial;
    assign dtrial = {dr_reg, dq_reg[15]} - {1'b0, dd_reg};

    // Execute result for the NAND, add and subtract operations.
    logic [15:0] alu;
    logic        alu_we;
    always_comb
    begin
        alu = 16'h0;
        alu_we = 1'b0;
        unique case (opc)
            sbrcpu_pkg::OP_NAND:
            begin
                alu = ~(a_reg & b_reg);
                alu_we = 1'b1;
            end
            sbrcpu_pkg::OP_NANDI:
            begin
                alu = ~(a_reg & imm_reg);
                alu_we = 1'b1;
            end
            sbrcpu_pkg::OP_ADD:
            begin
                alu = a_reg + b_reg;
                alu_we = 1'b1;
            end
            sbrcpu_pkg::OP_ADDI:
            begin
                alu = a_reg + imm_reg;
                alu_we = 1'b1;
            end
            sbrcpu_pkg::OP_SUB:
            begin
                alu = a_reg - b_reg;
                alu_we = 1'b1;
            end
            default:
            begin
                alu = 16'h0;
                alu_we = 1'b0;
            end
        endcase
    end

    logic [15:0] regs_next [15];
    logic [15:0] pc_w, fl;
    always_comb
    begin
        regs_next = regs_reg;
        pc_w = 16'h0;
        fl = 16'h0;
        if (cmd.pc_dec)
        begin
            regs_next[sbrcpu_pkg::REG_PC] = regs_reg[sbrcpu_pkg::REG_PC] - 16'd1;
        end
        if (cmd.write_back)
        begin
            if (cmd.lw_back && rd != sbrcpu_pkg::REG_ZERO)
            begin
                regs_next[rd] = mem_rdata;
            end
            if (alu_we && rd != sbrcpu_pkg::REG_ZERO)
            begin
                regs_next[rd] = alu;
            end
            if (opc == sbrcpu_pkg::OP_MUL)
            begin
                regs_next[sbrcpu_pkg::REG_HI] = prod[31:16];
                regs_next[sbrcpu_pkg::REG_LO] = prod[15:0];
            end
            if (opc == sbrcpu_pkg::OP_DIV && !dz_reg)
            begin
                regs_next[sbrcpu_pkg::REG_HI] = qneg_reg ? -dq_reg : dq_reg;
                regs_next[sbrcpu_pkg::REG_LO] = rneg_reg ? -dr_reg : dr_reg;
            end
            if (opc == sbrcpu_pkg::OP_CMP)
            begin
                fl = regs_reg[sbrcpu_pkg::REG_FLAG] & 16'hFFFC;
                fl[0] = (a_reg == b_reg);
                fl[1] = ($signed(a_reg) > $signed(b_reg));
                regs_next[sbrcpu_pkg::REG_FLAG] = fl;
            end
            if (opc == sbrcpu_pkg::OP_B
                || (opc == sbrcpu_pkg::OP_BEQ && regs_reg[sbrcpu_pkg::REG_FLAG][0])
                || (opc == sbrcpu_pkg::OP_BGT && regs_reg[sbrcpu_pkg::REG_FLAG][1]))
            begin
                regs_next[sbrcpu_pkg::REG_PC] = a_reg + 16'd1;
            end
            // Post-decrement of the program counter after the instruction.
            pc_w = regs_next[sbrcpu_pkg::REG_PC];
            regs_next[sbrcpu_pkg::REG_PC] = pc_w - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 15; i++)
            begin
                if (i == sbrcpu_pkg::REG_PC)
                begin
                    regs_reg[i] <= 16'(MEM_WORDS - 1);
                end
                else
                begin
                    regs_reg[i] <= 16'h0;
                end
            end
            halt_reg <= 1'b0;
            clr_reg <= '0;
            done_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
            done_reg <= cmd.emit;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.write_back && word_reg == sbrcpu_pkg::HALT_WORD)
            begin
                halt_reg <= 1'b1;
            end
            if (cmd.div_go)
            begin
                dcnt_reg <= 5'd16;
            end
            else if (cmd.div_step && dcnt_reg != 5'd0)
            begin
                dcnt_reg <= dcnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= item;
            word_reg <= 16'h0;
            fault_reg <= 1'b0;
        end
        if (cmd.latch_word)
        begin
            word_reg <= mem_rdata;
        end
        if (cmd.latch_ops)
        begin
            a_reg <= rget(regs_reg, (opc == sbrcpu_pkg::OP_MUL || opc == sbrcpu_pkg::OP_DIV
                                   || opc == sbrcpu_pkg::OP_CMP || opc == sbrcpu_pkg::OP_B
                                   || opc == sbrcpu_pkg::OP_BEQ || opc == sbrcpu_pkg::OP_BGT)
                                   ? rd : rs);
            b_reg <= rget(regs_reg, (opc == sbrcpu_pkg::OP_MUL || opc == sbrcpu_pkg::OP_DIV
                                   || opc == sbrcpu_pkg::OP_CMP) ? rs : rt);
            t_reg <= rget(regs_reg, rd);
        end
        if (cmd.latch_imm)
        begin
            imm_reg <= mem_rdata;
        end
        if (cmd.div_go)
        begin
            dq_reg <= a_reg[15] ? -a_reg : a_reg;
            dd_reg <= b_reg[15] ? -b_reg : b_reg;
            dr_reg <= 16'h0;
            qneg_reg <= a_reg[15] ^ b_reg[15];
            rneg_reg <= a_reg[15];
            dz_reg <= (b_reg == 16'h0);
            fault_reg <= (b_reg == 16'h0);
        end
        else if (cmd.div_step && dcnt_reg != 5'd0)
        begin
            if (!dtrial[16])
            begin
                dr_reg <= dtrial[15:0];
                dq_reg <= {dq_reg[14:0], 1'b1};
            end
            else
            begin
                dr_reg <= {dr_reg[14:0], dq_reg[15]};
                dq_reg <= {dq_reg[14:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            out_reg.read_value <= 16'h0;
            if (item_reg.command == sbrcpu_pkg::CMD_MEMRD)
            begin
                out_reg.read_value <= mem_rdata;
            end
            if (item_reg.command == sbrcpu_pkg::CMD_REGRD && item_reg.address[15:4] == 12'h0)
            begin
                out_reg.read_value <= rget(regs_reg, item_reg.address[3:0]);
            end
            out_reg.program_counter <= regs_reg[sbrcpu_pkg::REG_PC];
            out_reg.executed_word <= word_reg;
            out_reg.halted <= halt_reg;
            out_reg.divide_fault <= fault_reg;
            out_reg.flag_bits <= regs_reg[sbrcpu_pkg::REG_FLAG][1:0];
        end
    end

    assign stat.clr_last = (clr_reg == LAST_ADDR);
    assign stat.command = item_reg.command;
    assign stat.opcode = opc;
    assign stat.halted = halt_reg;
    assign stat.div_last = (dcnt_reg == 5'd0);
    assign done = done_reg;
    assign result = out_reg;
endmodule

@@ design/sixteen_bit_register_cpu_core.sv @@
// Top level of the sixteen-bit register CPU core.
// After reset the core clears its word memory, one word per cycle, across
// all MEM_WORDS words; busy stays high during that sweep. It then takes one
// command beat whenever start is high and busy is low, and returns exactly
// one result beat per command, marked by done for one cycle; the receiver
// cannot stall it. A load, a memory read, a register read or an execute
// while halted goes from the dispatch state straight to the done state. An
// execute works through the shared single-port memory (instruction fetch,
// optional immediate fetch, optional data access); a divide runs a
// one-bit-per-cycle divider. Memory is a single-port RAM, so fetch and data
// access are serialized.
module sixteen_bit_register_cpu_core #(
    parameter int MEM_WORDS = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sbrcpu_pkg::in_beat_t  item,
    output logic                  busy,
    output logic                  done,
    output sbrcpu_pkg::out_beat_t result
);
    sbrcpu_pkg::ctl_cmd_t cmd;
    sbrcpu_pkg::dp_stat_t stat;

    // Sequence each command beat through the datapath.
    sbrcpu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold architectural state and drive the result beat.
    sbrcpu_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );
endmodule

@@ design/sbrcpu_checker.sv @@
// Port checker for the CPU core, bound to the top level.
`include "sixteen_bit_register_cpu_core_defines.svh"
module sbrcpu_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input sbrcpu_pkg::out_beat_t result
);
    `SBR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SBR_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !done)
    `SBR_ASSERT_IMP(a_done_free, clk, rst_n, done, !busy)
    `SBR_ASSERT_NEXT(a_halt_sticky, clk, rst_n, done && result.halted, !done || result.halted)
endmodule

bind sixteen_bit_register_cpu_core sbrcpu_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sixteen-bit register CPU core.
module tb;
    import sbrcpu_pkg::*;

    localparam int MEM_WORDS = 65536;
    localparam logic [15:0] PC_RESET = 16'(MEM_WORDS - 1);

    logic      clk;
    logic      rst_n;
    logic      start;
    in_beat_t  item;
    logic      busy;
    logic      done;
    out_beat_t result;

    sixteen_bit_register_cpu_core #(.MEM_WORDS(MEM_WORDS)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Mirror of the core's architectural state.
    logic [15:0] shadow_mem [MEM_WORDS];
    logic [15:0] shadow_regs [16];
    logic        shadow_halt;

    out_beat_t   expected_beats [$];
    int          error_count = 0;

    // Directed stimulus; a row with has_answer set also carries the read value and
    // program counter it must produce.
    typedef struct {
        in_beat_t  beat;
        logic      has_answer;
        out_beat_t answer;
    } directed_row_t;

    directed_row_t directed_rows [$];

    function automatic logic [15:0] mem_addr(logic [31:0] a);
        return 16'((a & 32'hFFFF) % MEM_WORDS);
    endfunction

    function automatic logic [15:0] reg_get(logic [3:0] i);
        return (i == REG_ZERO) ? 16'h0 : shadow_regs[i];
    endfunction

    function automatic void reg_put(logic [3:0] i, logic [15:0] v);
        if (i != REG_ZERO)
            shadow_regs[i] = v;
    endfunction

    function automatic logic [15:0] take_imm();
        shadow_regs[REG_PC] = shadow_regs[REG_PC] - 16'd1;
        return shadow_mem[mem_addr(shadow_regs[REG_PC])];
    endfunction

    // Run one instruction on the shadow state; return 1 on a zero divisor.
    function automatic logic run_instruction(logic [15:0] w);
        logic [3:0]         op;
        logic [3:0]         rd;
        logic [3:0]         rs;
        logic [3:0]         rt;
        logic [15:0]        imm;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] p;
        logic [15:0]        f;
        logic               fault;
        op = w[15:12];
        rd = w[11:8];
        rs = w[7:4];
        rt = w[3:0];
        fault = 1'b0;
        a = 32'(signed'(reg_get(rd)));
        b = 32'(signed'(reg_get(rs)));
        case (op)
            OP_LW:
            begin
                imm = take_imm();
                reg_put(rd, shadow_mem[mem_addr(32'(16'(reg_get(rs) + imm)))]);
            end
            OP_SW:
            begin
                imm = take_imm();
                shadow_mem[mem_addr(32'(16'(reg_get(rs) + imm)))] = reg_get(rd);
            end
            OP_NAND:  reg_put(rd, ~(reg_get(rs) & reg_get(rt)));
            OP_NANDI:
            begin
                imm = take_imm();
                reg_put(rd, ~(reg_get(rs) & imm));
            end
            OP_ADD:   reg_put(rd, reg_get(rs) + reg_get(rt));
            OP_ADDI:
            begin
                imm = take_imm();
                reg_put(rd, reg_get(rs) + imm);
            end
            OP_SUB:   reg_put(rd, reg_get(rs) - reg_get(rt));
            OP_MUL:
            begin
                p = a * b;
                reg_put(REG_HI, p[31:16]);
                reg_put(REG_LO, p[15:0]);
            end
            OP_DIV:
            begin
                if (b == 0)
                    fault = 1'b1;
                else
                begin
                    reg_put(REG_HI, 16'(a / b));
                    reg_put(REG_LO, 16'(a % b));
                end
            end
            OP_CMP:
            begin
                f = shadow_regs[REG_FLAG] & ~16'd3;
                if (a == b)
                    f[0] = 1'b1;
                if (a > b)
                    f[1] = 1'b1;
                shadow_regs[REG_FLAG] = f;
            end
            OP_B:     reg_put(REG_PC, reg_get(rd) + 16'd1);
            OP_BEQ:
                if (shadow_regs[REG_FLAG][0])
                    reg_put(REG_PC, reg_get(rd) + 16'd1);
            OP_BGT:
                if (shadow_regs[REG_FLAG][1])
                    reg_put(REG_PC, reg_get(rd) + 16'd1);
            default: ;
        endcase
        shadow_regs[REG_PC] = shadow_regs[REG_PC] - 16'd1;
        return fault;
    endfunction

    // Apply one command to the shadow state and return the beat it should produce.
    function automatic out_beat_t predict_beat(in_beat_t c);
        out_beat_t o;
        o = '0;
        case (c.command)
            CMD_LOAD:  shadow_mem[mem_addr(c.address)] = c.data_word;
            CMD_EXEC:
                if (!shadow_halt)
                begin
                    o.executed_word = shadow_mem[mem_addr(shadow_regs[REG_PC])];
                    o.divide_fault = run_instruction(o.executed_word);
                    if (o.executed_word == HALT_WORD)
                        shadow_halt = 1'b1;
                end
            CMD_MEMRD: o.read_value = shadow_mem[mem_addr(c.address)];
            default:   o.read_value = (c.address < 16) ? reg_get(c.address[3:0]) : 16'h0;
        endcase
        o.program_counter = shadow_regs[REG_PC];
        o.halted = shadow_halt;
        o.flag_bits = shadow_regs[REG_FLAG][1:0];
        return o;
    endfunction

    // Compare each done beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                if (result !== expected_beats[0])
                begin
                    $display("%0t: beat mismatch, expected %h, actual %h",
                             $time, expected_beats[0], result);
                    error_count++;
                end
                void'(expected_beats.pop_front());
            end
        end
    end

    // Hold start low for a random gap: mostly short, sometimes long, often none.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(posedge clk);
    endtask

    // Present one beat and hold it until the core takes it; the core stays busy
    // for the cycle after the accepting edge, so drop start across that cycle.
    task automatic send_beat(in_beat_t c);
        start <= 1'b1;
        item <= c;
        do
            @(posedge clk);
        while (busy);
        expected_beats.push_back(predict_beat(c));
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_beat_t make_beat(logic [1:0] cmd, logic [15:0] a, logic [15:0] d);
        in_beat_t c;
        c.command = cmd;
        c.address = a;
        c.data_word = d;
        return c;
    endfunction

    task automatic add_row(logic [1:0] cmd, logic [15:0] a, logic [15:0] d);
        directed_row_t r;
        r.beat = make_beat(cmd, a, d);
        r.has_answer = 1'b0;
        r.answer = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_checked_row(logic [1:0] cmd, logic [15:0] a, logic [15:0] d,
                                   logic [15:0] rv, logic [15:0] pc);
        directed_row_t r;
        r.beat = make_beat(cmd, a, d);
        r.has_answer = 1'b1;
        r.answer = '0;
        r.answer.read_value = rv;
        r.answer.program_counter = pc;
        directed_rows.push_back(r);
    endtask

    function automatic logic [15:0] instr(logic [3:0] op, logic [3:0] rd,
                                          logic [3:0] rs, logic [3:0] rt);
        return {op, rd, rs, rt};
    endfunction

    // Random register-heavy instruction: most use registers 0..4 so values interact.
    function automatic logic [15:0] random_instr();
        logic [3:0] rd;
        logic [3:0] rs;
        rd = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
        rs = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
        return {4'($urandom_range(0, 15)), rd, rs, 4'($urandom)};
    endfunction

    // Write a short program at the current PC and run it.
    task automatic run_program_burst(ref int sent);
        logic [15:0] pc;
        logic [15:0] w;
        int          len;
        pc = shadow_regs[REG_PC];
        len = $urandom_range(2, 8);
        for (int i = 0; i < 2 * len; i++)
        begin
            w = (i % 2 == 0) ? random_instr() : 16'($urandom);
            // Rarely plant the halt word; branches land anywhere.
            if (i % 2 == 0 && $urandom_range(0, 60) == 0)
                w = HALT_WORD;
            idle_gap();
            send_beat(make_beat(CMD_LOAD, pc - 16'(i), w));
            sent++;
        end
        for (int i = 0; i < len; i++)
        begin
            idle_gap();
            send_beat(make_beat(CMD_EXEC, 16'($urandom), 16'($urandom)));
            sent++;
        end
    endtask

    initial
    begin
        int sent;
        out_beat_t got;
        start = 1'b0;
        item = '0;
        rst_n = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
            shadow_mem[i] = '0;
        for (int i = 0; i < 16; i++)
            shadow_regs[i] = '0;
        shadow_regs[REG_PC] = PC_RESET;
        shadow_halt = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, memory extremes and an out-of-range register.
        add_checked_row(CMD_REGRD, 16'd10, 16'h0, PC_RESET, PC_RESET);
        add_checked_row(CMD_MEMRD, 16'hFFFF, 16'h0, 16'h0, PC_RESET);
        add_checked_row(CMD_LOAD, 16'h0000, 16'hFFFF, 16'h0, PC_RESET);
        add_checked_row(CMD_MEMRD, 16'h0000, 16'h0, 16'hFFFF, PC_RESET);
        add_checked_row(CMD_REGRD, 16'hFFFF, 16'hFFFF, 16'h0, PC_RESET);
        // Program: addi r1 = 0x8000, nandi r2 = -1, div overflow, div by zero r15,
        // mul, cmp, sw/lw wrapping.
        add_row(CMD_LOAD, 16'hFFFF, instr(OP_ADDI, 4'd1, REG_ZERO, 4'd0));
        add_row(CMD_LOAD, 16'hFFFE, 16'h8000);
        add_row(CMD_LOAD, 16'hFFFD, instr(OP_NANDI, 4'd2, REG_ZERO, 4'd0));
        add_row(CMD_LOAD, 16'hFFFC, 16'h0000);
        add_row(CMD_LOAD, 16'hFFFB, instr(OP_DIV, 4'd1, 4'd2, 4'd0));
        add_row(CMD_LOAD, 16'hFFFA, instr(OP_DIV, 4'd1, REG_ZERO, 4'd0));
        add_row(CMD_LOAD, 16'hFFF9, instr(OP_MUL, 4'd1, 4'd1, 4'd0));
        add_row(CMD_LOAD, 16'hFFF8, instr(OP_CMP, 4'd2, 4'd1, 4'd0));
        add_row(CMD_LOAD, 16'hFFF7, instr(OP_SW, 4'd2, 4'd2, 4'd0));
        add_row(CMD_LOAD, 16'hFFF6, 16'h0005);
        add_row(CMD_LOAD, 16'hFFF5, instr(OP_LW, 4'd3, 4'd2, 4'd0));
        add_row(CMD_LOAD, 16'hFFF4, 16'h0005);
        for (int i = 0; i < 8; i++)
            add_row(CMD_EXEC, 16'h0, 16'h0);
        add_checked_row(CMD_REGRD, 16'd15, 16'h0, 16'h0, 16'hFFF3);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].beat);
            if (directed_rows[i].has_answer)
            begin
                got = expected_beats[$];
                if (got.read_value !== directed_rows[i].answer.read_value
                    || got.program_counter !== directed_rows[i].answer.program_counter)
                begin
                    $display("%0t: directed row %0d, expected %h, actual %h",
                             $time, i, directed_rows[i].answer, got);
                    error_count++;
                end
            end
        end

        // Remaining ops in order: add, sub, nand, beq not taken, then bgt taken
        // through r3 back to the top of memory, where the addi runs again.
        sent = directed_rows.size();
        begin
            logic [15:0] prog [$];
            logic [15:0] pc;
            prog = {instr(OP_ADD, 4'd4, 4'd1, 4'd2), instr(OP_SUB, 4'd5, 4'd1, 4'd2),
                    instr(OP_NAND, 4'd6, 4'd1, 4'd2), instr(OP_BEQ, 4'd6, 4'd0, 4'd0),
                    instr(OP_BGT, 4'd3, 4'd0, 4'd0)};
            pc = shadow_regs[REG_PC];
            foreach (prog[i])
                send_beat(make_beat(CMD_LOAD, pc - 16'(i), prog[i]));
            for (int i = 0; i < 6; i++)
                send_beat(make_beat(CMD_EXEC, 16'h0, 16'h0));
            sent += 11;
        end

        // Random part: mostly small programs, with stray reads and loads as noise.
        while (sent < 540)
        begin
            case ($urandom_range(0, 5))
                0:       send_beat(make_beat(CMD_MEMRD, 16'($urandom), 16'($urandom)));
                1:       send_beat(make_beat(CMD_REGRD,
                             ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 15)),
                             16'($urandom)));
                2:       send_beat(make_beat(CMD_LOAD, 16'($urandom), 16'($urandom)));
                default: run_program_burst(sent);
            endcase
            sent++;
            idle_gap();
        end

        // Halt word, an execute that runs it, then executes that must do nothing, then a read still works.
        send_beat(make_beat(CMD_LOAD, shadow_regs[REG_PC], HALT_WORD));
        for (int i = 0; i < 3; i++)
            send_beat(make_beat(CMD_EXEC, 16'h0, 16'h0));
        send_beat(make_beat(CMD_REGRD, 16'd10, 16'h0));

        // Drain, then allow a divide's worth of further cycles.
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Clearing sweep plus ~560 beats with their idle gaps, several times over.
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
